[rtl/dcd_pkg.sv]
// Shared types, codes and helpers for the drive command decoder.
package dcd_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_PACKET = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LINK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_APPLY_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACTIVE_HIGH  = 2'd2;

  // Reset values and saturation limits
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd200;
  localparam logic [15:0] APPLY_PERIOD_RST = 16'd10;
  localparam logic [7:0]  SPEED_RST        = 8'd160;
  localparam logic [7:0]  SPEED_MAX        = 8'd255;
  localparam logic [15:0] MS_SAT           = 16'hFFFF;
  localparam logic [8:0]  NUM_SAT          = 9'd256;

  // Direction codes, two's complement
  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  // Wheel on-patterns, bit0 FR, bit1 FL, bit2 BL, bit3 BR
  localparam logic [3:0] WHEELS_ALL   = 4'b1111;
  localparam logic [3:0] WHEELS_LEFT  = 4'b0110;
  localparam logic [3:0] WHEELS_RIGHT = 4'b1001;
  localparam logic [3:0] WHEELS_NONE  = 4'b0000;

  // Characters
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Speed number parser phase
  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } num_phase_t;

  // Partial text line
  typedef struct packed {
    logic [7:0] lead;
    logic       has_lead;
    num_phase_t phase;
    logic       negative;
    logic [8:0] value;
  } line_st_t;

  // Command decoded at the end of a text line
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_FWD,
    CMD_BACK,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_STOP,
    CMD_SPEED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] speed;
  } line_cmd_t;

  // Pin levels from an on-pattern under the polarity setting
  function automatic logic [3:0] wheel_pins(input logic [3:0] on, input logic active_high);
    return on ^ {4{~active_high}};
  endfunction

  // Sign of an 8-bit signed value as a direction code
  function automatic logic [1:0] sign8(input logic [7:0] raw);
    logic [1:0] d;
    if (raw == 8'd0) d = DIR_ZERO;
    else if (raw[7]) d = DIR_NEG;
    else d = DIR_POS;
    return d;
  endfunction

endpackage

[rtl/dcd_line.sv]
// Text line parser: next line state and the command a line end yields.
module dcd_line
  import dcd_pkg::*;
(
  input  line_st_t   line_i,
  input  logic [7:0] byte_i,
  output line_st_t   line_o,
  output line_cmd_t  cmd_o
);

  logic        blank;
  logic        digit;
  logic        eol;
  logic [3:0]  dval;
  logic [11:0] acc;
  line_st_t    num;

  assign blank = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
  assign digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign eol   = (byte_i == CH_LF) || (byte_i == CH_CR);
  assign dval  = 4'(byte_i - CH_ZERO);

  // value * 10 + digit, only used while collecting digits
  always_comb begin
    if (line_i.phase == PH_DIGITS)
      acc = ({3'd0, line_i.value} << 3) + ({3'd0, line_i.value} << 1) + {8'd0, dval};
    else
      acc = {8'd0, dval};
  end

  // Speed number step
  always_comb begin
    num = line_i;
    unique case (line_i.phase)
      PH_BLANK: begin
        if (!blank) begin
          if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
            num.negative = (byte_i == CH_MINUS);
            num.phase    = PH_SIGN;
          end else if (digit) begin
            num.value = {5'd0, dval};
            num.phase = PH_DIGITS;
          end else begin
            num.phase = PH_DONE;
          end
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (digit) begin
          num.value = (acc > 12'(NUM_SAT)) ? NUM_SAT : acc[8:0];
          num.phase = PH_DIGITS;
        end else begin
          num.phase = PH_DONE;
        end
      end
      PH_DONE: ;
    endcase
  end

  // Line state and end-of-line decode
  always_comb begin
    line_o     = line_i;
    cmd_o.kind = CMD_NONE;
    cmd_o.speed = 8'd0;
    if (eol) begin
      line_o = '0;
      if (line_i.has_lead) begin
        unique case (line_i.lead)
          CH_F: cmd_o.kind = CMD_FWD;
          CH_B: cmd_o.kind = CMD_BACK;
          CH_L: cmd_o.kind = CMD_LEFT;
          CH_R: cmd_o.kind = CMD_RIGHT;
          CH_S: cmd_o.kind = CMD_STOP;
          CH_V: cmd_o.kind = CMD_SPEED;
          default: cmd_o.kind = CMD_NONE;
        endcase
      end
      if (line_i.negative)
        cmd_o.speed = 8'd0;
      else if (line_i.value > {1'b0, SPEED_MAX})
        cmd_o.speed = SPEED_MAX;
      else
        cmd_o.speed = line_i.value[7:0];
    end else if (!line_i.has_lead) begin
      if (!blank) begin
        line_o          = '0;
        line_o.lead     = byte_i;
        line_o.has_lead = 1'b1;
      end
    end else if (line_i.lead == CH_V) begin
      line_o = num;
    end
  end

endmodule

[rtl/drive_command_decoder_failsafe.sv]
// Drive command decoder with link-loss failsafe: top level.
//
// Input words carry one item each: in_tuser selects a 1 ms tick, a binary
// drive packet or one byte of a text command line; in_tdata carries the
// packet fields and the text byte. Every accepted word yields exactly one
// output word showing the wheel pin levels, duty and held drive state
// after that item.
// Latency: the output word is valid the cycle after its input is taken.
// Throughput: one word per cycle while the receiver keeps up; the state update for
// an item is combinational logic between the state and output registers.
// in_tready stays high while the output register is empty or being read,
// so an input is taken in the same cycle the waiting result leaves. When
// the receiver stalls, the result holds and in_tready drops.
// Reset (rst_n low, synchronous): configuration returns to timeout 200,
// apply period 10, active-low wheels; the drive is braked, speed 160,
// sequence 0, and no output word is pending. The user must write configuration
// through cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module drive_command_decoder_failsafe
  import dcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [47:0] in_tdata,   // seq, throttle_raw, steer_raw, speed_req, text_byte
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // front_right_level, front_left_level, back_left_level, back_right_level,
  // duty, cur_throttle, cur_steer, cur_speed
  output logic [23:0] out_tdata,
  // Configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] link_timeout_r;
  logic [15:0] apply_period_r;
  logic        active_high_r;

  // Drive state
  logic [15:0] last_seq_r, last_seq_nxt;
  logic [1:0]  thr_r, thr_nxt;
  logic [1:0]  str_r, str_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] period_r, period_nxt;
  line_st_t    line_r, line_nxt;
  logic [3:0]  wheels_r, wheels_nxt;
  logic [7:0]  duty_r, duty_nxt;

  // Output register
  logic        out_valid_r;
  logic [23:0] out_data_r;

  // Input fields
  logic [15:0] f_seq;
  logic [7:0]  f_thr, f_str, f_speed, f_text;
  logic        accept;

  // Tick path intermediates
  logic [15:0] idle_inc, period_inc;
  logic [1:0]  thr_t, str_t;
  logic        timed_out;

  line_st_t    line_text;
  line_cmd_t   cmd;

  assign f_seq   = in_tdata[15:0];
  assign f_thr   = in_tdata[23:16];
  assign f_str   = in_tdata[31:24];
  assign f_speed = in_tdata[39:32];
  assign f_text  = in_tdata[47:40];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  dcd_line u_line (
    .line_i (line_r),
    .byte_i (f_text),
    .line_o (line_text),
    .cmd_o  (cmd)
  );

  assign idle_inc   = (idle_r != MS_SAT) ? idle_r + 16'd1 : idle_r;
  assign period_inc = (period_r != MS_SAT) ? period_r + 16'd1 : period_r;
  assign timed_out  = idle_inc > link_timeout_r;
  assign thr_t      = timed_out ? DIR_ZERO : thr_r;
  assign str_t      = timed_out ? DIR_ZERO : str_r;

  // Next state for the current item
  always_comb begin
    last_seq_nxt = last_seq_r;
    thr_nxt      = thr_r;
    str_nxt      = str_r;
    speed_nxt    = speed_r;
    idle_nxt     = idle_r;
    period_nxt   = period_r;
    line_nxt     = line_r;
    wheels_nxt   = wheels_r;
    duty_nxt     = duty_r;
    case (in_tuser)
      ACT_TICK: begin
        idle_nxt = idle_inc;
        thr_nxt  = thr_t;
        str_nxt  = str_t;
        if (timed_out) begin
          wheels_nxt = wheel_pins(WHEELS_ALL, active_high_r);
          duty_nxt   = 8'd0;
        end
        if (period_inc >= apply_period_r) begin
          period_nxt = 16'd0;
          duty_nxt   = speed_r;
          if (thr_t == DIR_ZERO && str_t == DIR_ZERO) begin
            wheels_nxt = wheel_pins(WHEELS_ALL, active_high_r);
            duty_nxt   = 8'd0;
          end else if (str_t == DIR_NEG) begin
            wheels_nxt = wheel_pins(WHEELS_LEFT, active_high_r);
          end else if (str_t == DIR_POS) begin
            wheels_nxt = wheel_pins(WHEELS_RIGHT, active_high_r);
          end else if (thr_t == DIR_POS) begin
            wheels_nxt = wheel_pins(WHEELS_NONE, active_high_r);
          end else begin
            wheels_nxt = wheel_pins(WHEELS_ALL, active_high_r);
          end
        end else begin
          period_nxt = period_inc;
        end
      end
      ACT_PACKET: begin
        if (f_seq > last_seq_r) begin
          last_seq_nxt = f_seq;
          thr_nxt      = sign8(f_thr);
          str_nxt      = sign8(f_str);
          speed_nxt    = f_speed;
          idle_nxt     = 16'd0;
        end
      end
      ACT_TEXT: begin
        line_nxt = line_text;
        unique case (cmd.kind)
          CMD_NONE: ;
          CMD_FWD: begin
            thr_nxt = DIR_POS; str_nxt = DIR_ZERO; idle_nxt = 16'd0;
          end
          CMD_BACK: begin
            thr_nxt = DIR_NEG; str_nxt = DIR_ZERO; idle_nxt = 16'd0;
          end
          CMD_LEFT: begin
            str_nxt = DIR_NEG; idle_nxt = 16'd0;
          end
          CMD_RIGHT: begin
            str_nxt = DIR_POS; idle_nxt = 16'd0;
          end
          CMD_STOP: begin
            thr_nxt    = DIR_ZERO;
            str_nxt    = DIR_ZERO;
            wheels_nxt = wheel_pins(WHEELS_ALL, active_high_r);
            duty_nxt   = 8'd0;
            idle_nxt   = 16'd0;
          end
          CMD_SPEED: begin
            speed_nxt = cmd.speed;
            idle_nxt  = 16'd0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_timeout_r <= LINK_TIMEOUT_RST;
      apply_period_r <= APPLY_PERIOD_RST;
      active_high_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_TIMEOUT: link_timeout_r <= cfg_wdata;
        REG_APPLY_PERIOD: apply_period_r <= cfg_wdata;
        REG_ACTIVE_HIGH:  active_high_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Drive state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= 16'd0;
      thr_r      <= DIR_ZERO;
      str_r      <= DIR_ZERO;
      speed_r    <= SPEED_RST;
      idle_r     <= 16'd0;
      period_r   <= 16'd0;
      line_r     <= '0;
      wheels_r   <= wheel_pins(WHEELS_ALL, 1'b0);
      duty_r     <= 8'd0;
    end else if (accept) begin
      last_seq_r <= last_seq_nxt;
      thr_r      <= thr_nxt;
      str_r      <= str_nxt;
      speed_r    <= speed_nxt;
      idle_r     <= idle_nxt;
      period_r   <= period_nxt;
      line_r     <= line_nxt;
      wheels_r   <= wheels_nxt;
      duty_r     <= duty_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {speed_nxt, str_nxt, thr_nxt, duty_nxt, wheels_nxt};
    end
  end

endmodule

[rtl/dcd_checker.sv]
// Port-level checks for the drive command decoder, bound to the top level.
module dcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // A pending word blocks new input until taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result pending");

  // Held directions are -1, 0 or 1
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:12] != 2'b10) && (out_tdata[15:14] != 2'b10))
    else $error("illegal direction code");

  // Reset drops any pending word
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind drive_command_decoder_failsafe dcd_checker u_dcd_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the drive command decoder with link-loss failsafe.
`timescale 1ns / 100ps

module tb_top;
  import dcd_pkg::*;

  // Action code that the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Blanks without a constant in the package
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [1:0]  act;
    logic [47:0] data;
  } drive_item_t;

  // Same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [7:0] speed;
    logic [1:0] steer;
    logic [1:0] throttle;
    logic [7:0] duty;
    logic [3:0] pins;
  } drive_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = ACT_TICK;  // action
  logic [47:0] in_tdata = '0;        // seq, throttle_raw, steer_raw, speed_req, text_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // front_right_level, front_left_level, back_left_level, back_right_level,
  // duty, cur_throttle, cur_steer, cur_speed
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LINK_TIMEOUT;
  logic [15:0] cfg_wdata = '0;

  drive_command_decoder_failsafe dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  drive_item_t   pending_words[$];
  drive_status_t status_due[$];

  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int items_queued = 0;
  int long_holds = 0;
  int in_gap_max = 4;
  int out_gap_max = 4;
  int gen_seq = 0;
  int cycle_count = 0;

  // Coverage tallies for the summary
  int packets_taken = 0;
  int lines_run = 0;
  int link_brakes = 0;
  int wheel_updates = 0;

  // Register copies
  logic [15:0] c_timeout = LINK_TIMEOUT_RST;
  logic [15:0] c_period = APPLY_PERIOD_RST;
  logic        c_active_high = 1'b0;

  // Predicted drive state, at reset values
  logic [15:0] p_last_seq = '0;
  logic [1:0]  p_throttle = DIR_ZERO;
  logic [1:0]  p_steer = DIR_ZERO;
  logic [7:0]  p_speed = SPEED_RST;
  logic [15:0] p_idle = '0;
  logic [15:0] p_period = '0;
  logic [7:0]  p_lead = '0;
  logic        p_has_lead = 1'b0;
  num_phase_t  p_phase = PH_BLANK;
  logic        p_negative = 1'b0;
  logic [8:0]  p_number = '0;
  logic [3:0]  p_pins = 4'b0000;  // all wheels on, active low
  logic [7:0]  p_duty = '0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic void set_wheels(logic [3:0] on);
    p_pins = c_active_high ? on : ~on;
  endfunction

  function automatic void brake_wheels();
    set_wheels(WHEELS_ALL);
    p_duty = '0;
  endfunction

  function automatic logic [1:0] dir_of(logic [7:0] raw);
    if (raw == 8'd0) return DIR_ZERO;
    return raw[7] ? DIR_NEG : DIR_POS;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void update_wheels();
    wheel_updates++;
    if (p_throttle == DIR_ZERO && p_steer == DIR_ZERO) begin
      brake_wheels();
    end else begin
      if (p_steer == DIR_NEG) set_wheels(WHEELS_LEFT);
      else if (p_steer == DIR_POS) set_wheels(WHEELS_RIGHT);
      else if (p_throttle == DIR_POS) set_wheels(WHEELS_NONE);
      else set_wheels(WHEELS_ALL);
      p_duty = p_speed;
    end
  endfunction

  function automatic void clear_line();
    p_lead = '0;
    p_has_lead = 1'b0;
    p_phase = PH_BLANK;
    p_negative = 1'b0;
    p_number = '0;
  endfunction

  // Speed digits after a V lead
  function automatic void speed_char(logic [7:0] c);
    logic digit;
    int v;
    digit = (c >= CH_ZERO && c <= CH_NINE);
    if (p_phase == PH_BLANK) begin
      if (is_blank(c)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        p_negative = (c == CH_MINUS);
        p_phase = PH_SIGN;
      end else if (digit) begin
        p_number = 9'(c - CH_ZERO);
        p_phase = PH_DIGITS;
      end else begin
        p_phase = PH_DONE;
      end
    end else if (p_phase == PH_SIGN || p_phase == PH_DIGITS) begin
      if (digit) begin
        v = (p_phase == PH_DIGITS) ? int'(p_number) * 10 : 0;
        v += int'(c) - int'(CH_ZERO);
        p_number = (v > int'(NUM_SAT)) ? NUM_SAT : 9'(v);
        p_phase = PH_DIGITS;
      end else begin
        p_phase = PH_DONE;
      end
    end
  endfunction

  // End of a text line: run the command named by its lead
  function automatic void end_line();
    if (p_has_lead) begin
      lines_run++;
      case (p_lead)
        CH_F: begin p_throttle = DIR_POS; p_steer = DIR_ZERO; p_idle = '0; end
        CH_B: begin p_throttle = DIR_NEG; p_steer = DIR_ZERO; p_idle = '0; end
        CH_L: begin p_steer = DIR_NEG; p_idle = '0; end
        CH_R: begin p_steer = DIR_POS; p_idle = '0; end
        CH_S: begin
          p_throttle = DIR_ZERO;
          p_steer = DIR_ZERO;
          brake_wheels();
          p_idle = '0;
        end
        CH_V: begin
          if (p_negative) p_speed = '0;
          else p_speed = (p_number > 9'(SPEED_MAX)) ? SPEED_MAX : p_number[7:0];
          p_idle = '0;
        end
        default: lines_run--;
      endcase
    end
    clear_line();
  endfunction

  function automatic void predict_drive_status(logic [1:0] act, logic [47:0] d);
    logic [7:0] c;
    c = d[47:40];
    case (act)
      ACT_TICK: begin
        if (p_idle != MS_SAT) p_idle++;
        if (p_period != MS_SAT) p_period++;
        if (p_idle > c_timeout) begin
          link_brakes++;
          p_throttle = DIR_ZERO;
          p_steer = DIR_ZERO;
          brake_wheels();
        end
        if (p_period >= c_period) begin
          p_period = '0;
          update_wheels();
        end
      end
      ACT_PACKET: begin
        if (d[15:0] > p_last_seq) begin
          packets_taken++;
          p_last_seq = d[15:0];
          p_throttle = dir_of(d[23:16]);
          p_steer = dir_of(d[31:24]);
          p_speed = d[39:32];
          p_idle = '0;
        end
      end
      ACT_TEXT: begin
        if (c == CH_LF || c == CH_CR) begin
          end_line();
        end else if (!p_has_lead) begin
          if (!is_blank(c)) begin
            p_lead = c;
            p_has_lead = 1'b1;
            p_phase = PH_BLANK;
            p_negative = 1'b0;
            p_number = '0;
          end
        end else if (p_lead == CH_V) begin
          speed_char(c);
        end
      end
      default: ;
    endcase
    status_due.push_back('{speed: p_speed, steer: p_steer, throttle: p_throttle,
                           duty: p_duty, pins: p_pins});
  endfunction

  // ---------------------------------------------------------------------
  // Driver: input words from the pending queue
  // ---------------------------------------------------------------------
  int in_wait = 0;
  drive_item_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        words_in++;
        predict_drive_status(in_tuser, in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0) begin
          in_wait <= in_wait - 1;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_tuser <= next_word.act;
          in_tdata <= next_word.data;
          in_tvalid <= 1'b1;
          in_wait <= $urandom_range(0, in_gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: receiver stalls and field checks
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  int out_wait = 0;
  int out_gap;
  drive_status_t want_word, got_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      words_out++;
      got_word = drive_status_t'(out_tdata);
      if (status_due.size() == 0) begin
        $error("output word %h with no prediction pending", out_tdata);
        errors++;
      end else begin
        want_word = status_due.pop_front();
        check_field("front_right_level", want_word.pins[0], got_word.pins[0]);
        check_field("front_left_level", want_word.pins[1], got_word.pins[1]);
        check_field("back_left_level", want_word.pins[2], got_word.pins[2]);
        check_field("back_right_level", want_word.pins[3], got_word.pins[3]);
        check_field("duty", want_word.duty, got_word.duty);
        check_field("cur_throttle", want_word.throttle, got_word.throttle);
        check_field("cur_steer", want_word.steer, got_word.steer);
        check_field("cur_speed", want_word.speed, got_word.speed);
      end
      // long hold while the sender still has plenty queued
      if (long_holds < 2 && pending_words.size() > 30 &&
          words_out >= 150 + 450 * long_holds) begin
        long_holds++;
        out_gap = LONG_HOLD;
      end else begin
        out_gap = $urandom_range(0, out_gap_max);
      end
      out_wait <= out_gap;
      out_tready <= (out_gap == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_tready <= (out_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words in, %0d out",
               cycle_count, words_in, words_out);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [47:0] rand_fill();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic void add_item(logic [1:0] act, logic [47:0] data);
    pending_words.push_back('{act: act, data: data});
    items_queued++;
  endfunction

  function automatic void add_tick();
    add_item(ACT_TICK, rand_fill());
  endfunction

  function automatic void add_packet(logic [15:0] seq, logic [7:0] thr, logic [7:0] str,
                                     logic [7:0] spd);
    logic [47:0] r;
    r = rand_fill();
    add_item(ACT_PACKET, {r[47:40], spd, str, thr, seq});
  endfunction

  function automatic void add_char(logic [7:0] c);
    logic [47:0] r;
    r = rand_fill();
    add_item(ACT_TEXT, {c, r[39:0]});
  endfunction

  function automatic void add_line(string s, logic [7:0] term);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    add_char(term);
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] rand_dir_byte();
    return ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
  endfunction

  function automatic void add_new_packet();
    gen_seq += $urandom_range(1, 40);
    add_packet(16'(gen_seq), rand_dir_byte(), rand_dir_byte(), 8'($urandom));
  endfunction

  // Text line with random blanks, lead and tail; now and then a packet inside
  function automatic void add_rand_line();
    logic [7:0] lead;
    int pick;
    repeat ($urandom_range(0, 2)) add_char(rand_blank());
    pick = $urandom_range(0, 9);
    case (pick)
      0: lead = CH_F;
      1: lead = CH_B;
      2: lead = CH_L;
      3: lead = CH_R;
      4: lead = CH_S;
      5, 6: lead = CH_V;
      7, 8: lead = 8'($urandom_range(33, 126));
      default: lead = CH_SPACE;
    endcase
    if (lead != CH_SPACE) add_char(lead);
    if ($urandom_range(0, 9) == 0) add_new_packet();
    if (lead == CH_V) begin
      repeat ($urandom_range(0, 2)) add_char(rand_blank());
      case ($urandom_range(0, 3))
        0: add_char(CH_PLUS);
        1: add_char(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
        add_char(8'($urandom_range(33, 126)));
        add_char(CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end else begin
      repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(32, 126)));
    end
    add_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 5) == 0) add_char(CH_LF);
  endfunction

  function automatic void add_random(int n);
    int goal, pick;
    goal = items_queued + n;
    while (items_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) repeat ($urandom_range(1, 8)) add_tick();
      else if (pick < 60) add_new_packet();
      else if (pick < 65)
        add_packet(16'($urandom_range(0, gen_seq)), rand_dir_byte(), rand_dir_byte(),
                   8'($urandom));
      else if (pick < 93) add_rand_line();
      else if (pick < 97) add_char(8'($urandom));
      else add_item(ACT_UNUSED, rand_fill());
    end
  endfunction

  task automatic set_config(logic [15:0] to, logic [15:0] per, logic ah);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LINK_TIMEOUT;
    cfg_wdata <= to;
    @(posedge clk);
    cfg_index <= REG_APPLY_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_index <= REG_ACTIVE_HIGH;
    cfg_wdata <= {15'd0, ah};
    @(posedge clk);
    cfg_we <= 1'b0;
    c_timeout = to;
    c_period = per;
    c_active_high = ah;
    @(negedge clk);
  endtask

  // Wait until every queued word went in and every prediction was met
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || status_due.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] to, logic [15:0] per, logic ah,
                           int in_gap, int out_gap, int n);
    set_config(to, per, ah);
    in_gap_max = in_gap;
    out_gap_max = out_gap;
    add_random(n);
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short timeout, update every tick, active-high wheels
    set_config(16'd3, 16'd1, 1'b1);
    add_packet(16'd1, 8'h7F, 8'h00, 8'd255);
    add_tick();                                 // straight forward
    add_packet(16'd2, 8'h80, 8'h00, 8'd0);
    add_tick();                                 // straight back at speed 0
    add_packet(16'd2, 8'h01, 8'h01, 8'd9);      // equal sequence, dropped
    add_line("\tL", CH_LF);
    add_tick();                                 // turn left
    add_line("V999", CH_CR);                    // saturates to 255
    add_line("V-1", CH_LF);                     // negative gives 0
    add_item(ACT_UNUSED, rand_fill());
    add_line("S", CH_CR);                       // brakes at once
    add_line("", CH_CR);                        // empty line
    add_packet(16'd3, 8'h01, 8'hFF, 8'd77);     // turn left
    repeat (4) add_tick();                      // link loss on the fourth
    gen_seq = 3;
    drain();

    // Random phases over several register settings
    run_phase(LINK_TIMEOUT_RST, APPLY_PERIOD_RST, 1'b0, 4, 4, 200);
    run_phase(16'd0, 16'd1, 1'b1, 4, 0, 100);
    run_phase(16'hFFFF, 16'hFFFF, 1'b0, 0, 4, 100);
    run_phase(16'($urandom_range(5, 40)), 16'd0, 1'b1, 0, 0, 200);
    run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(1, 8)),
              1'($urandom_range(0, 1)), 4, 4, 300);

    // Top sequence number: no packet accepted afterwards
    set_config(16'd12, 16'd2, 1'b0);
    in_gap_max = 4;
    out_gap_max = 4;
    add_random(60);
    add_packet(16'hFFFF, rand_dir_byte(), rand_dir_byte(), 8'($urandom));
    add_tick();
    add_tick();
    repeat (6) add_packet(16'($urandom), rand_dir_byte(), rand_dir_byte(), 8'($urandom));
    add_packet(16'hFFFF, 8'h01, 8'h01, 8'd1);
    gen_seq = 65535;
    add_random(40);
    drain();

    $display("Covered %0d words (%0d checked), %0d packets taken, %0d text commands,",
             words_in, words_out, packets_taken, lines_run);
    $display("%0d link-loss brakes, %0d wheel updates, %0d long receiver holds",
             link_brakes, wheel_updates, long_holds);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[drive_command_decoder_failsafe.f]
rtl/dcd_pkg.sv
rtl/dcd_line.sv
rtl/drive_command_decoder_failsafe.sv
rtl/dcd_checker.sv
dv/tb_top.sv
